FILE: rtl/core/nbra_pkg.sv
// package for the nb-iot random access retry control block
// types, codes and level-select helpers used by nbra_ctrl, nbra_dp, the top level and the tb; no dependencies
`default_nettype none
package nbra_pkg;

	localparam int MAX_LEVELS = 3;
	localparam int LVL_W      = 2;
	localparam int TTI_W      = 32;
	localparam int HALF_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int DIV_CNT_W  = $clog2(TTI_W);

	localparam logic [1:0] CMD_START   = 2'd0;
	localparam logic [1:0] CMD_TRY     = 2'd1;
	localparam logic [1:0] CMD_FAILED  = 2'd2;
	localparam logic [1:0] CMD_RESOLVE = 2'd3;

	localparam logic [2:0] ACT_NONE      = 3'd0;
	localparam logic [2:0] ACT_SEND      = 3'd1;
	localparam logic [2:0] ACT_WAIT      = 3'd2;
	localparam logic [2:0] ACT_RESTART   = 3'd3;
	localparam logic [2:0] ACT_FAIL      = 3'd4;
	localparam logic [2:0] ACT_REFRESH   = 3'd5;
	localparam logic [2:0] ACT_CONNECTED = 3'd6;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_LEVEL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMITS       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PERIODS      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSETS      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SUBCARRIERS  = 3'd6;

	typedef struct packed {
		logic accept;
		logic div_load;
		logic div_step;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
	} dp_sts_t;

	function automatic logic [LVL_W-1:0] lvl_clamp(input logic [LVL_W-1:0] lv);
		lvl_clamp = (int'(lv) < MAX_LEVELS) ? lv : LVL_W'(MAX_LEVELS - 1);
	endfunction

	function automatic logic [BYTE_W-1:0] byte_of(input logic [3*BYTE_W-1:0] packed_v,
		input logic [LVL_W-1:0] lv);
		logic [LVL_W-1:0] c;
		c = lvl_clamp(lv);
		case (c)
			2'd0:    byte_of = packed_v[BYTE_W-1:0];
			2'd1:    byte_of = packed_v[2*BYTE_W-1:BYTE_W];
			default: byte_of = packed_v[3*BYTE_W-1:2*BYTE_W];
		endcase
	endfunction

	function automatic logic [HALF_W-1:0] half_of(input logic [3*HALF_W-1:0] packed_v,
		input logic [LVL_W-1:0] lv);
		logic [LVL_W-1:0] c;
		c = lvl_clamp(lv);
		case (c)
			2'd0:    half_of = packed_v[HALF_W-1:0];
			2'd1:    half_of = packed_v[2*HALF_W-1:HALF_W];
			default: half_of = packed_v[3*HALF_W-1:2*HALF_W];
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/nbra_if.sv
// valid/ready channel interfaces for request and result beats
// depends on nothing but the field widths of the block
`default_nettype none
interface nbra_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] tti;
	logic        opportunity_open;
	logic        node_active;

	modport source (output valid, cmd, tti, opportunity_open, node_active, input ready);
	modport sink (input valid, cmd, tti, opportunity_open, node_active, output ready);
endinterface

interface nbra_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [15:0] wait_ticks;
	logic [7:0]  subcarrier_count;
	logic [1:0]  level_now;
	logic [7:0]  attempts_now;
	logic [7:0]  level_attempts_now;

	modport source (output valid, action, wait_ticks, subcarrier_count, level_now,
		attempts_now, level_attempts_now, input ready);
	modport sink (input valid, action, wait_ticks, subcarrier_count, level_now,
		attempts_now, level_attempts_now, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/nbra_ctrl.sv
// controller state machine: accept, evaluate, divide, deliver
// uses nbra_pkg for the command and status structs
`default_nettype none
module nbra_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output nbra_pkg::dp_cmd_t      dp_cmd,
	input  wire nbra_pkg::dp_sts_t dp_sts
);
	import nbra_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DIV, S_DONE} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign req_ready       = (state_q == S_IDLE);
	assign rsp_valid       = out_valid_q;
	assign dp_cmd.accept   = req_valid && req_ready;
	assign dp_cmd.div_load = (state_q == S_EVAL) && dp_sts.need_div;
	assign dp_cmd.div_step = (state_q == S_DIV);
	assign dp_cmd.commit   = (state_q == S_DONE) && (!out_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (dp_cmd.accept)
						state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= dp_sts.need_div ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (dp_sts.div_last)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (dp_cmd.commit)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (dp_cmd.commit)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.accept |=> state_q == S_EVAL)
		else $error("accepted beat did not enter evaluation");

	a_rsp_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(dp_cmd.commit))
		else $error("result beat raised without commit");

	a_commit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp_ready && state_q == S_DONE) |=> state_q == S_DONE)
		else $error("pending result overwritten");

	a_div_ends_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && dp_sts.div_last) |=> state_q == S_DONE && !req_ready)
		else $error("division did not finish into delivery");

endmodule
`default_nettype wire

FILE: rtl/core/nbra_dp.sv
// datapath: config registers, procedure state, bit-serial remainder unit, result register
// uses nbra_pkg for codes, level helpers and the command and status structs
`default_nettype none
module nbra_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [nbra_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [nbra_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [1:0]                       in_cmd,
	input  wire logic [31:0]                      in_tti,
	input  wire logic                             in_open,
	input  wire logic                             in_active,
	input  wire nbra_pkg::dp_cmd_t                dp_cmd,
	output nbra_pkg::dp_sts_t                     dp_sts,
	output logic [2:0]                            out_action,
	output logic [15:0]                           out_wait,
	output logic [7:0]                            out_subc,
	output logic [1:0]                            out_level,
	output logic [7:0]                            out_attempts,
	output logic [7:0]                            out_lvl_attempts
);
	import nbra_pkg::*;

	logic [BYTE_W-1:0]   max_att_q;
	logic [LVL_W-1:0]    home_q;
	logic [LVL_W-1:0]    lcount_q;
	logic [3*BYTE_W-1:0] limits_q;
	logic [3*HALF_W-1:0] periods_q;
	logic [3*HALF_W-1:0] offsets_q;
	logic [3*BYTE_W-1:0] subc_q;

	logic              proc_q;
	logic [BYTE_W-1:0] tot_q;
	logic [BYTE_W-1:0] lvf_q;
	logic [LVL_W-1:0]  lvl_q;

	logic [1:0]       cmd_q;
	logic [TTI_W-1:0] tti_q;
	logic             open_q;
	logic             active_q;

	logic [TTI_W-1:0]     dvd_q;
	logic [HALF_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [HALF_W-1:0] period;
	logic [HALF_W-1:0] offset;
	logic              pre_offset;
	logic              try_eval;
	logic [HALF_W:0]   trial;
	logic [HALF_W:0]   trial_sub;

	logic              nxt_proc;
	logic [BYTE_W-1:0] nxt_tot;
	logic [BYTE_W-1:0] nxt_lvf;
	logic [LVL_W-1:0]  nxt_lvl;
	logic [2:0]        res_act;
	logic [HALF_W-1:0] res_wait;
	logic [2:0]        try_act;
	logic [HALF_W-1:0] try_wait;
	logic [LVL_W-1:0]  levels;
	logic [BYTE_W-1:0] inc_tot;
	logic [BYTE_W-1:0] inc_lvf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_att_q <= 8'd10;
			home_q    <= 2'd0;
			lcount_q  <= 2'd3;
			limits_q  <= 24'd197379;
			periods_q <= 48'd171801313320;
			offsets_q <= 48'd0;
			subc_q    <= 24'd789516;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAX_ATTEMPTS: max_att_q <= cfg_data[BYTE_W-1:0];
				REG_HOME_LEVEL:   home_q    <= cfg_data[LVL_W-1:0];
				REG_LEVEL_COUNT:  lcount_q  <= cfg_data[LVL_W-1:0];
				REG_LIMITS:       limits_q  <= cfg_data[3*BYTE_W-1:0];
				REG_PERIODS:      periods_q <= cfg_data[3*HALF_W-1:0];
				REG_OFFSETS:      offsets_q <= cfg_data[3*HALF_W-1:0];
				REG_SUBCARRIERS:  subc_q    <= cfg_data[3*BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.accept) begin
			cmd_q    <= in_cmd;
			tti_q    <= in_tti;
			open_q   <= in_open;
			active_q <= in_active;
		end
	end

	// period of zero counts as one
	always_comb begin
		period = half_of(periods_q, lvl_q);
		if (period == '0)
			period = HALF_W'(1);
		offset     = half_of(offsets_q, lvl_q);
		pre_offset = tti_q < {{(TTI_W-HALF_W){1'b0}}, offset};
		try_eval   = (cmd_q == CMD_TRY) || (cmd_q == CMD_START && !active_q && !proc_q);
	end

	assign dp_sts.need_div = try_eval && !pre_offset;
	assign dp_sts.div_last = (cnt_q == DIV_CNT_W'(TTI_W - 1));

	// restoring remainder, one dividend bit per cycle
	assign trial     = {rem_q, dvd_q[TTI_W-1]};
	assign trial_sub = trial - {1'b0, period};

	always_ff @(posedge clk) begin
		if (dp_cmd.div_load) begin
			dvd_q <= tti_q - {{(TTI_W-HALF_W){1'b0}}, offset};
			rem_q <= '0;
			cnt_q <= '0;
		end else if (dp_cmd.div_step) begin
			dvd_q <= {dvd_q[TTI_W-2:0], 1'b0};
			rem_q <= (trial >= {1'b0, period}) ? trial_sub[HALF_W-1:0] : trial[HALF_W-1:0];
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

	always_comb begin
		if (pre_offset) begin
			try_act  = ACT_WAIT;
			try_wait = offset - tti_q[HALF_W-1:0];
		end else if (open_q && rem_q == '0) begin
			try_act  = ACT_SEND;
			try_wait = '0;
		end else begin
			try_act  = ACT_WAIT;
			try_wait = period - rem_q;
		end

		levels  = (int'(lcount_q) < MAX_LEVELS) ? lcount_q : LVL_W'(MAX_LEVELS);
		inc_tot = (tot_q == '1) ? tot_q : tot_q + BYTE_W'(1);
		inc_lvf = (lvf_q == '1) ? lvf_q : lvf_q + BYTE_W'(1);

		nxt_proc = proc_q;
		nxt_tot  = tot_q;
		nxt_lvf  = lvf_q;
		nxt_lvl  = lvl_q;
		res_act  = ACT_NONE;
		res_wait = '0;
		case (cmd_q)
			CMD_START: begin
				if (active_q) begin
					res_act = ACT_REFRESH;
				end else if (!proc_q) begin
					nxt_proc = 1'b1;
					res_act  = try_act;
					res_wait = try_wait;
				end
			end
			CMD_TRY: begin
				res_act  = try_act;
				res_wait = try_wait;
			end
			CMD_FAILED: begin
				if (proc_q) begin
					nxt_proc = 1'b0;
					nxt_tot  = inc_tot;
					nxt_lvf  = inc_lvf;
					if (inc_tot < max_att_q) begin
						if (inc_lvf >= byte_of(limits_q, lvl_q) &&
							({1'b0, lvl_q} + 3'd1) < {1'b0, levels}) begin
							nxt_lvl = lvl_q + LVL_W'(1);
							nxt_lvf = '0;
						end
						res_act = ACT_RESTART;
					end else begin
						nxt_tot = '0;
						nxt_lvf = '0;
						nxt_lvl = lvl_clamp(home_q);
						res_act = ACT_FAIL;
					end
				end
			end
			default: begin
				nxt_proc = 1'b0;
				nxt_tot  = '0;
				nxt_lvf  = '0;
				nxt_lvl  = lvl_clamp(home_q);
				res_act  = ACT_CONNECTED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_q <= 1'b0;
			tot_q  <= '0;
			lvf_q  <= '0;
			lvl_q  <= '0;
		end else if (dp_cmd.commit) begin
			proc_q <= nxt_proc;
			tot_q  <= nxt_tot;
			lvf_q  <= nxt_lvf;
			lvl_q  <= nxt_lvl;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.commit) begin
			out_action       <= res_act;
			out_wait         <= res_wait;
			out_subc         <= byte_of(subc_q, nxt_lvl);
			out_level        <= nxt_lvl;
			out_attempts     <= nxt_tot;
			out_lvl_attempts <= nxt_lvf;
		end
	end

	a_level_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(lvl_q) < MAX_LEVELS)
		else $error("coverage level out of range");

endmodule
`default_nettype wire

FILE: rtl/core/nbiot_random_access_retry_control_top.sv
// top level of the nb-iot random access retry control block
// instantiates nbra_ctrl and nbra_dp; uses nbra_pkg and the nbra_if channel interfaces
//
//  channel | dir | payload
//  --------+-----+---------------------------------------------------------------
//  req     | in  | cmd, tti, opportunity_open, node_active
//  rsp     | out | action, wait_ticks, subcarrier_count, level_now, attempts_now,
//          |     | level_attempts_now
//  cfg     | in  | cfg_we, cfg_idx, cfg_data (write only)
//
// a start or try beat that is evaluated at or past its level's offset passes through the
// evaluation state, the remainder unit (one bit per cycle) and the commit state; every other
// beat goes from evaluation straight to commit. one beat is in work at a time and the next is
// taken the cycle after commit. the result sits in an output register, so the next beat is
// taken while it waits; a beat ready to commit stalls until that result is taken. reset
// clears state and loads defaults.
`default_nettype none
module nbiot_random_access_retry_control_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [nbra_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [nbra_pkg::CFG_DATA_W-1:0]  cfg_data,
	nbra_req_if.sink                              req,
	nbra_rsp_if.source                            rsp
);
	import nbra_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	nbra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.dp_cmd    (dp_cmd),
		.dp_sts    (dp_sts)
	);

	nbra_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_data         (cfg_data),
		.in_cmd           (req.cmd),
		.in_tti           (req.tti),
		.in_open          (req.opportunity_open),
		.in_active        (req.node_active),
		.dp_cmd           (dp_cmd),
		.dp_sts           (dp_sts),
		.out_action       (rsp.action),
		.out_wait         (rsp.wait_ticks),
		.out_subc         (rsp.subcarrier_count),
		.out_level        (rsp.level_now),
		.out_attempts     (rsp.attempts_now),
		.out_lvl_attempts (rsp.level_attempts_now)
	);

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for nbiot_random_access_retry_control_top: predicts every response
// beat from its own retry/escalation model and drives random valid/ready traffic across configs
// depends on nbra_pkg, nbra_req_if/nbra_rsp_if and the rtl under rtl/core
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import nbra_pkg::*;

	localparam int STALL_LIMIT     = 3000;
	localparam int RSP_HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS     = 100;
	localparam int PHASES          = 6;

	typedef enum {CFG_RANDOM, CFG_ALL_ONES, CFG_ALL_ZERO, CFG_DEFAULTS} cfg_kind_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] wait_ticks;
		logic [7:0]  subcarriers;
		logic [1:0]  level;
		logic [7:0]  attempts;
		logic [7:0]  level_attempts;
	} ra_result_t;

	class ra_attempt_tracker;
		logic [7:0]  max_attempts;
		logic [1:0]  home_level;
		logic [1:0]  level_count;
		logic [23:0] limits;
		logic [47:0] periods;
		logic [47:0] offsets;
		logic [23:0] subcarriers;
		logic        running;
		logic [7:0]  total_fail;
		logic [7:0]  level_fail;
		logic [1:0]  level;
		ra_result_t  due_results[$];
		int          mismatches;

		function new();
			max_attempts = 8'd10;
			home_level   = 2'd0;
			level_count  = 2'd3;
			limits       = 24'd197379;
			periods      = 48'd171801313320;
			offsets      = 48'd0;
			subcarriers  = 24'd789516;
			running      = 1'b0;
			total_fail   = 8'd0;
			level_fail   = 8'd0;
			level        = 2'd0;
			mismatches   = 0;
		endfunction

		function logic [1:0] capped(input logic [1:0] lv);
			return (int'(lv) < MAX_LEVELS) ? lv : 2'(MAX_LEVELS - 1);
		endfunction

		function logic [7:0] byte_at(input logic [23:0] pk, input logic [1:0] lv);
			return 8'(pk >> (8 * int'(capped(lv))));
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_MAX_ATTEMPTS: max_attempts = val[7:0];
				REG_HOME_LEVEL:   home_level   = val[1:0];
				REG_LEVEL_COUNT:  level_count  = val[1:0];
				REG_LIMITS:       limits       = val[23:0];
				REG_PERIODS:      periods      = val[47:0];
				REG_OFFSETS:      offsets      = val[47:0];
				REG_SUBCARRIERS:  subcarriers  = val[23:0];
				default: ;
			endcase
		endfunction

		// period (zero counts as one) and offset of the level in use
		function void grid_of_level(output logic [31:0] per, output logic [31:0] off);
			per = {16'd0, 16'(periods >> (16 * int'(capped(level))))};
			off = {16'd0, 16'(offsets >> (16 * int'(capped(level))))};
			if (per == 0)
				per = 32'd1;
		endfunction

		function void judge_grid(input logic [31:0] tti, input logic opp,
			output logic [2:0] act, output logic [15:0] wt);
			logic [31:0] per;
			logic [31:0] off;
			logic [31:0] rem;
			grid_of_level(per, off);
			wt = '0;
			if (tti < off) begin
				act = ACT_WAIT;
				wt  = 16'(off - tti);
			end else begin
				rem = (tti - off) % per;
				if (opp && rem == 0) begin
					act = ACT_SEND;
				end else begin
					act = ACT_WAIT;
					wt  = 16'(per - rem);
				end
			end
		endfunction

		function void go_home();
			total_fail = 8'd0;
			level_fail = 8'd0;
			level      = capped(home_level);
		endfunction

		function void note_request(input logic [1:0] cmd, input logic [31:0] tti,
			input logic opp, input logic active);
			ra_result_t r;
			logic [2:0] act;
			logic [15:0] wt;
			int levels;
			act    = ACT_NONE;
			wt     = '0;
			levels = (int'(level_count) < MAX_LEVELS) ? int'(level_count) : MAX_LEVELS;
			case (cmd)
				CMD_START: begin
					if (active) begin
						act = ACT_REFRESH;
					end else if (!running) begin
						running = 1'b1;
						judge_grid(tti, opp, act, wt);
					end
				end
				CMD_TRY: judge_grid(tti, opp, act, wt);
				CMD_FAILED: begin
					if (running) begin
						running = 1'b0;
						if (total_fail != 8'hFF)
							total_fail++;
						if (level_fail != 8'hFF)
							level_fail++;
						if (total_fail < max_attempts) begin
							if (level_fail >= byte_at(limits, level) && int'(level) + 1 < levels) begin
								level++;
								level_fail = 8'd0;
							end
							act = ACT_RESTART;
						end else begin
							go_home();
							act = ACT_FAIL;
						end
					end
				end
				default: begin
					running = 1'b0;
					go_home();
					act = ACT_CONNECTED;
				end
			endcase
			r.action         = act;
			r.wait_ticks     = wt;
			r.subcarriers    = byte_at(subcarriers, level);
			r.level          = level;
			r.attempts       = total_fail;
			r.level_attempts = level_fail;
			due_results.push_back(r);
		endfunction

		function void compare_field(input string name, input longint unsigned want,
			input longint unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(input ra_result_t got);
			ra_result_t want;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected beat action=%0d wait_ticks=%0d level=%0d", $time,
					got.action, got.wait_ticks, got.level);
				mismatches++;
				return;
			end
			want = due_results.pop_front();
			compare_field("action", 64'(want.action), 64'(got.action));
			compare_field("wait_ticks", 64'(want.wait_ticks), 64'(got.wait_ticks));
			compare_field("subcarrier_count", 64'(want.subcarriers), 64'(got.subcarriers));
			compare_field("level_now", 64'(want.level), 64'(got.level));
			compare_field("attempts_now", 64'(want.attempts), 64'(got.attempts));
			compare_field("level_attempts_now", 64'(want.level_attempts),
				64'(got.level_attempts));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic [CFG_DATA_W-1:0] cfg_set [7];
	bit                    calm;
	bit                    rsp_hold_req;
	ra_attempt_tracker     sb = new();

	nbra_req_if req_ch ();
	nbra_rsp_if rsp_ch ();

	nbiot_random_access_retry_control_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_req(input logic [1:0] cmd, input logic [31:0] tti, input logic opp,
		input logic active);
		if (!calm && $urandom_range(0, 99) < 6) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		req_ch.valid            <= 1'b1;
		req_ch.cmd              <= cmd;
		req_ch.tti              <= tti;
		req_ch.opportunity_open <= opp;
		req_ch.node_active      <= active;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(cmd, tti, opp, active);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.due_results.size() != 0);
	endtask

	task automatic load_config();
		for (int i = 0; i <= int'(REG_SUBCARRIERS); i++) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= CFG_IDX_W'(i);
			cfg_data <= cfg_set[CFG_IDX_W'(i)];
			@(posedge clk);
			sb.write_reg(CFG_IDX_W'(i), cfg_set[CFG_IDX_W'(i)]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic choose_config(input cfg_kind_t kind);
		logic [15:0] per;
		case (kind)
			CFG_DEFAULTS: begin
				cfg_set[REG_MAX_ATTEMPTS] = 48'd10;
				cfg_set[REG_HOME_LEVEL]   = 48'd0;
				cfg_set[REG_LEVEL_COUNT]  = 48'd3;
				cfg_set[REG_LIMITS]       = 48'd197379;
				cfg_set[REG_PERIODS]      = 48'd171801313320;
				cfg_set[REG_OFFSETS]      = 48'd0;
				cfg_set[REG_SUBCARRIERS]  = 48'd789516;
			end
			CFG_ALL_ONES: foreach (cfg_set[i]) cfg_set[i] = '1;
			CFG_ALL_ZERO: foreach (cfg_set[i]) cfg_set[i] = '0;
			default: begin
				cfg_set[REG_MAX_ATTEMPTS] = 48'($urandom_range(1, 12));
				cfg_set[REG_HOME_LEVEL]   = 48'($urandom_range(0, 3));
				cfg_set[REG_LEVEL_COUNT]  = 48'($urandom_range(0, 3));
				cfg_set[REG_LIMITS]       = '0;
				cfg_set[REG_PERIODS]      = '0;
				cfg_set[REG_OFFSETS]      = '0;
				cfg_set[REG_SUBCARRIERS]  = 48'($urandom_range(0, 24'hFFFFFF));
				for (int l = 0; l < MAX_LEVELS; l++) begin
					cfg_set[REG_LIMITS][8*l +: 8] = 8'($urandom_range(0, 4));
					case ($urandom_range(0, 7))
						0:       per = 16'd0;
						1:       per = 16'($urandom_range(0, 65535));
						default: per = 16'($urandom_range(1, 50));
					endcase
					cfg_set[REG_PERIODS][16*l +: 16] = per;
					cfg_set[REG_OFFSETS][16*l +: 16] = ($urandom_range(0, 7) == 0) ?
						16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 60));
				end
			end
		endcase
	endtask

	// on the grid, ahead of the offset, or anywhere
	function automatic logic [31:0] pick_tti();
		logic [31:0] per;
		logic [31:0] off;
		sb.grid_of_level(per, off);
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return (off == 0) ? $urandom : $urandom_range(0, off - 1);
			default: return off + per * $urandom_range(0, 40);
		endcase
	endfunction

	task automatic run_phase(input int n_items, input bit with_pressure);
		int sent;
		int tries;
		int roll;
		bit held;
		bit paused;
		logic [1:0] cmd;
		sent   = 0;
		held   = 1'b0;
		paused = 1'b0;
		while (sent < n_items) begin
			if (with_pressure && !held && sent >= 30) begin
				held         = 1'b1;
				rsp_hold_req = 1'b1;
			end
			if (with_pressure && !paused && sent >= 60) begin
				paused = 1'b1;
				drain_results();
			end
			roll = $urandom_range(0, 99);
			if (roll < 80) begin
				send_req(CMD_START, pick_tti(), $urandom_range(0, 3) != 0, $urandom_range(0, 9) == 0);
				tries = $urandom_range(0, 3);
				repeat (tries)
					send_req(CMD_TRY, pick_tti(), $urandom_range(0, 3) != 0,
						$urandom_range(0, 1) != 0);
				roll = $urandom_range(0, 99);
				if (roll < 80)
					send_req(CMD_FAILED, $urandom, $urandom_range(0, 1) != 0,
						$urandom_range(0, 1) != 0);
				else if (roll < 95)
					send_req(CMD_RESOLVE, $urandom, $urandom_range(0, 1) != 0,
						$urandom_range(0, 1) != 0);
				sent += tries + 2;
			end else begin
				cmd = 2'($urandom_range(0, 3));
				send_req(cmd, $urandom, $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
				sent++;
			end
		end
	endtask

	initial begin : rsp_side
		int hold_left;
		ra_result_t got;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.action         = rsp_ch.action;
				got.wait_ticks     = rsp_ch.wait_ticks;
				got.subcarriers    = rsp_ch.subcarrier_count;
				got.level          = rsp_ch.level_now;
				got.attempts       = rsp_ch.attempts_now;
				got.level_attempts = rsp_ch.level_attempts_now;
				sb.check_result(got);
			end
			if (rsp_hold_req) begin
				rsp_hold_req = 1'b0;
				hold_left    = RSP_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 6);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin : stimulus
		cfg_kind_t kind;
		calm                    = 1'b0;
		rsp_hold_req            = 1'b0;
		arst_n                  <= 1'b0;
		req_ch.valid            <= 1'b0;
		req_ch.cmd              <= CMD_START;
		req_ch.tti              <= '0;
		req_ch.opportunity_open <= 1'b0;
		req_ch.node_active      <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_idx                 <= REG_MAX_ATTEMPTS;
		cfg_data                <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// level 0 zero period, level 1 offset ahead, level 2 widest period
		cfg_set[REG_MAX_ATTEMPTS] = 48'd5;
		cfg_set[REG_HOME_LEVEL]   = 48'd1;
		cfg_set[REG_LEVEL_COUNT]  = 48'd3;
		cfg_set[REG_LIMITS]       = 48'h020101;
		cfg_set[REG_PERIODS]      = {16'hFFFF, 16'd10, 16'd0};
		cfg_set[REG_OFFSETS]      = {16'd7, 16'd100, 16'd0};
		cfg_set[REG_SUBCARRIERS]  = 48'h300C03;
		load_config();
		send_req(CMD_START, 32'd0, 1'b1, 1'b1);
		send_req(CMD_FAILED, 32'd0, 1'b0, 1'b0);
		send_req(CMD_START, 32'hFFFF_FFFF, 1'b1, 1'b0);
		send_req(CMD_START, 32'd3, 1'b1, 1'b0);
		send_req(CMD_TRY, 32'd5, 1'b0, 1'b0);
		send_req(CMD_FAILED, 32'd0, 1'b0, 1'b0);
		send_req(CMD_START, 32'd3, 1'b1, 1'b0);
		send_req(CMD_TRY, 32'd110, 1'b1, 1'b0);
		send_req(CMD_TRY, 32'd113, 1'b1, 1'b1);
		send_req(CMD_FAILED, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_req(CMD_START, 32'd0, 1'b1, 1'b0);
		send_req(CMD_TRY, 32'd7, 1'b1, 1'b0);
		send_req(CMD_TRY, 32'hFFFF_FFFF, 1'b1, 1'b0);
		send_req(CMD_FAILED, 32'd0, 1'b0, 1'b0);
		send_req(CMD_START, 32'd65542, 1'b0, 1'b0);
		send_req(CMD_FAILED, 32'd0, 1'b0, 1'b0);
		send_req(CMD_START, 32'd8, 1'b1, 1'b0);
		send_req(CMD_FAILED, 32'd0, 1'b0, 1'b0);
		send_req(CMD_START, 32'd50, 1'b1, 1'b0);
		send_req(CMD_RESOLVE, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_req(CMD_TRY, 32'd0, 1'b0, 1'b1);
		drain_results();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				1:       kind = CFG_ALL_ONES;
				2:       kind = CFG_ALL_ZERO;
				4:       kind = CFG_DEFAULTS;
				default: kind = CFG_RANDOM;
			endcase
			choose_config(kind);
			load_config();
			calm = (phase == 3);
			run_phase(PHASE_ITEMS, phase == 0);
			calm = 1'b0;
			drain_results();
		end

		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.due_results.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule

FILE: nbiot_random_access_retry_control_top.f
rtl/core/nbra_pkg.sv
rtl/core/nbra_if.sv
rtl/core/nbra_ctrl.sv
rtl/core/nbra_dp.sv
rtl/core/nbiot_random_access_retry_control_top.sv
tb/tb_top.sv
